### rtl/ghct_pkg.sv
package ghct_pkg;

  // result kinds
  localparam logic [1:0] KIND_TERM = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // results per input transaction, the last slot is kept for an error or end
  localparam int MAX_RESULTS_PER_ITEM = 64;
  localparam int CNT_W = $clog2(MAX_RESULTS_PER_ITEM + 1);

  localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

  // request to the shared shift/add unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] opa;
    logic [63:0] opb;
  } unit_req_t;

  // response of the shared shift/add unit
  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] res;
  } unit_rsp_t;

endpackage

### rtl/ghct_if.sv
interface ghct_in_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic        last_term;
  logic [63:0] part_num;
  logic [63:0] part_den;
  modport source (output valid, first, last_term, part_num, part_den, input ready);
  modport sink (input valid, first, last_term, part_num, part_den, output ready);
endinterface

interface ghct_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] term;
  logic [1:0]  kind;
  logic        last_of_run;
  modport source (output valid, term, kind, last_of_run, input ready);
  modport sink (input valid, term, kind, last_of_run, output ready);
endinterface

### rtl/ghct_unit.sv
module ghct_unit (
  input  logic                clk,
  input  logic                rst,
  input  ghct_pkg::unit_req_t req,
  output ghct_pkg::unit_rsp_t rsp
);
  import ghct_pkg::*;

  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic        fin;
  logic        neg;
  logic        lost;
  logic        ovf;
  logic        is_div;

  logic [64:0] mul_sum;
  logic [64:0] div_rem;
  logic        div_ge;
  logic [63:0] mag;

  // one step of shift-add multiply or restoring divide
  assign mul_sum = {1'b0, acc} + {1'b0, ua};
  assign div_rem = {acc, ua[63]};
  assign div_ge  = div_rem >= {1'b0, ub};
  assign mag     = is_div ? ua : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ua     <= req.opa[63] ? 64'd0 - req.opa : req.opa;
        ub     <= req.opb[63] ? 64'd0 - req.opb : req.opb;
        neg    <= req.opa[63] ^ req.opb[63];
        is_div <= req.is_div;
        acc    <= '0;
        lost   <= 1'b0;
        ovf    <= 1'b0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (is_div) begin
          // the remainder stays below the divisor, so 64 bits hold it
          acc <= div_ge ? div_rem[63:0] - ub : div_rem[63:0];
          ua  <= {ua[62:0], div_ge};
        end else begin
          if (ub[0]) begin
            acc <= mul_sum[63:0];
            if (mul_sum[64] || lost) ovf <= 1'b1;
          end
          lost <= lost | ua[63];
          ua   <= {ua[62:0], 1'b0};
          ub   <= {1'b0, ub[63:1]};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        // apply sign and range check of the magnitude
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        rsp.res  <= neg ? 64'd0 - mag : mag;
        rsp.ovf  <= !is_div && (ovf || (neg ? (mag > S64_MIN) : mag[63]));
      end
    end
  end

endmodule

### rtl/generalized_cf_homographic_transform.sv
// Homographic transform (a*x + b) / (c*x + d) of a generalized continued
// fraction into a regular continued fraction.
// items: one transaction per input term (first, last_term, part_num,
// part_den). first reloads a, b, c, d from the four configuration registers.
// results: term, kind (term, end, error) and last_of_run on the final
// result of an input term. Configuration through an APB port, 64-bit
// registers at byte addresses 0, 8, 16 and 24.
// Each emitted term takes four passes through the shared shift/add unit (two
// divides, two multiplies); taking in a term takes four multiplies. An item
// that arrives while stopped is accepted and ignored unless it has first set.
// items.ready is high only while no input term is being worked on.
// Results pass through a one-entry hold register and an output register;
// when the receiver stalls the sequencer waits and nothing is lost.
// Reset clears the sequencer, restores a=1 b=0 c=0 d=1 in the registers and
// the working coefficients and clears the stopped flag.
module generalized_cf_homographic_transform (
  input  logic        clk,
  input  logic        rst,
  ghct_in_if.sink     items,
  ghct_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ghct_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_DIV0  = 4'd3;
  localparam logic [3:0] S_ADJ   = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL0  = 4'd6;
  localparam logic [3:0] S_SUBS  = 4'd7;
  localparam logic [3:0] S_RET   = 4'd8;
  localparam logic [3:0] S_ABS1  = 4'd9;
  localparam logic [3:0] S_ABS2  = 4'd10;
  localparam logic [3:0] S_ABS3  = 4'd11;
  localparam logic [3:0] S_ABS4  = 4'd12;
  localparam logic [3:0] S_PUT   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd1;
  localparam logic [1:0] PH_INF   = 2'd2;

  logic [3:0]  state;
  logic [3:0]  put_ret;
  logic [1:0]  put_kind;
  logic [63:0] put_term;
  logic [1:0]  ph;
  logic [CNT_W-1:0] n;

  logic [63:0] init_num_hi, init_num_lo, init_den_hi, init_den_lo;
  logic [63:0] coef_a, coef_b, coef_c, coef_d;
  logic        done_flag;
  logic [63:0] p, q;
  logic        last_r;
  logic [63:0] q1, t1, m1, na;
  logic        wait_u;

  logic        pend_valid;
  logic [63:0] pend_term;
  logic [1:0]  pend_kind;
  logic        out_valid;
  logic [63:0] out_term;
  logic [1:0]  out_kind;
  logic        out_last;

  unit_req_t   u_req;
  unit_rsp_t   u_rsp;

  logic        out_free;
  logic        out_load;
  logic        op_state;
  logic [64:0] diff_c, diff_d, sum_w;
  logic        in_acc;
  logic        cfg_wr;

  ghct_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (u_req),
    .rsp (u_rsp)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_acc = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);

  assign results.valid       = out_valid;
  assign results.term        = out_term;
  assign results.kind        = out_kind;
  assign results.last_of_run = out_last;

  assign out_free = !out_valid || results.ready;

  // held result moves into the output register this cycle
  assign out_load = (state == S_PUT || state == S_FIN) && pend_valid && out_free;

  // register readback
  always_comb begin
    case (paddr[4:3])
      2'd0:    prdata = init_num_hi;
      2'd1:    prdata = init_num_lo;
      2'd2:    prdata = init_den_hi;
      default: prdata = init_den_lo;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    u_req.is_div = 1'b0;
    u_req.opa    = coef_a;
    u_req.opb    = q;
    op_state     = 1'b1;
    case (state)
      S_DIV1: begin u_req.is_div = 1'b1; u_req.opa = coef_a; u_req.opb = coef_c; end
      S_DIV0: begin u_req.is_div = 1'b1; u_req.opa = coef_b; u_req.opb = coef_d; end
      S_MUL1: begin u_req.opa = q1; u_req.opb = coef_c; end
      S_MUL0: begin u_req.opa = q1; u_req.opb = coef_d; end
      S_ABS1: begin u_req.opa = coef_a; u_req.opb = q; end
      S_ABS2: begin u_req.opa = coef_b; u_req.opb = p; end
      S_ABS3: begin u_req.opa = coef_c; u_req.opb = q; end
      S_ABS4: begin u_req.opa = coef_d; u_req.opb = p; end
      default: op_state = 1'b0;
    endcase
    u_req.start = op_state && !wait_u;
  end

  // 65-bit differences and sum for range checks
  assign diff_c = {coef_a[63], coef_a} - {t1[63], t1};
  assign diff_d = {coef_b[63], coef_b} - {u_rsp.res[63], u_rsp.res};
  assign sum_w  = {m1[63], m1} + {u_rsp.res[63], u_rsp.res};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_num_hi <= 64'd1;
      init_num_lo <= 64'd0;
      init_den_hi <= 64'd0;
      init_den_lo <= 64'd1;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        2'd0:    init_num_hi <= pwdata;
        2'd1:    init_num_lo <= pwdata;
        2'd2:    init_den_hi <= pwdata;
        default: init_den_lo <= pwdata;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      coef_a     <= 64'd1;
      coef_b     <= 64'd0;
      coef_c     <= 64'd0;
      coef_d     <= 64'd1;
      done_flag  <= 1'b0;
      wait_u     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      ph         <= PH_FIRST;
      n          <= '0;
    end else begin
      if (out_valid && results.ready && !out_load) out_valid <= 1'b0;
      if (u_req.start) wait_u <= 1'b1;
      if (u_rsp.done) wait_u <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            p      <= items.part_num;
            q      <= items.part_den;
            last_r <= items.last_term;
            ph     <= PH_FIRST;
            n      <= '0;
            if (items.first) begin
              coef_a    <= init_num_hi;
              coef_b    <= init_num_lo;
              coef_c    <= init_den_hi;
              coef_d    <= init_den_lo;
              done_flag <= 1'b0;
              state     <= S_CHECK;
            end else if (!done_flag) begin
              state <= S_CHECK;
            end
          end
        end

        // end of expansion, a zero denominator, divide overflow
        S_CHECK: begin
          if (coef_c == 64'd0 && coef_d == 64'd0) begin
            put_kind  <= KIND_END;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else if (coef_c == 64'd0 || coef_d == 64'd0) begin
            state <= S_RET;
          end else if ((coef_a == S64_MIN && coef_c == '1) ||
                       (coef_b == S64_MIN && coef_d == '1)) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else begin
            state <= S_DIV1;
          end
        end

        S_DIV1: if (u_rsp.done) begin
          q1    <= u_rsp.res;
          state <= S_DIV0;
        end

        S_DIV0: if (u_rsp.done) state <= S_ADJ;

        // compare quotients, lower a negative one by one, or error on the most negative
        S_ADJ: begin
          if (q1 != u_rsp.res) begin
            state <= S_RET;
          end else if (q1[63] && q1 == S64_MIN) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else begin
            if (q1[63]) q1 <= q1 - 64'd1;
            state <= S_MUL1;
          end
        end

        S_MUL1: if (u_rsp.done) begin
          if (u_rsp.ovf) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else begin
            t1    <= u_rsp.res;
            state <= S_MUL0;
          end
        end

        S_MUL0: if (u_rsp.done) state <= S_SUBS;

        // new coefficients and emit the term, or an error on overflow or the result limit
        S_SUBS: begin
          if (u_rsp.ovf || diff_c[64] != diff_c[63] || diff_d[64] != diff_d[63] ||
              n >= CNT_W'(MAX_RESULTS_PER_ITEM - 1)) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
          end else begin
            put_kind <= KIND_TERM;
            put_term <= q1;
            put_ret  <= S_CHECK;
            coef_a   <= coef_c;
            coef_b   <= coef_d;
            coef_c   <= diff_c[63:0];
            coef_d   <= diff_d[63:0];
          end
          state <= S_PUT;
        end

        // emit loop ended without stopping
        S_RET: begin
          case (ph)
            PH_FIRST: state <= S_ABS1;
            PH_LAST: begin
              coef_b <= coef_a;
              coef_d <= coef_c;
              ph     <= PH_INF;
              state  <= S_CHECK;
            end
            default: state <= S_FIN;
          endcase
        end

        S_ABS1, S_ABS3: if (u_rsp.done) begin
          if (u_rsp.ovf) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else begin
            m1    <= u_rsp.res;
            state <= (state == S_ABS1) ? S_ABS2 : S_ABS4;
          end
        end

        S_ABS2, S_ABS4: if (u_rsp.done) begin
          if (u_rsp.ovf || sum_w[64] != sum_w[63]) begin
            put_kind  <= KIND_ERR;
            put_term  <= 64'd0;
            put_ret   <= S_FIN;
            done_flag <= 1'b1;
            state     <= S_PUT;
          end else if (state == S_ABS2) begin
            na    <= sum_w[63:0];
            state <= S_ABS3;
          end else begin
            coef_b <= coef_a;
            coef_a <= na;
            coef_d <= coef_c;
            coef_c <= sum_w[63:0];
            if (last_r) begin
              ph    <= PH_LAST;
              state <= S_CHECK;
            end else begin
              state <= S_FIN;
            end
          end
        end

        // push a result through the hold register
        S_PUT: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_term  <= pend_term;
              out_kind  <= pend_kind;
              out_last  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_term  <= put_term;
            pend_kind  <= put_kind;
            n          <= n + CNT_W'(1);
            state      <= put_ret;
          end
        end

        // release the held result as the final one of the transaction
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_term   <= pend_term;
            out_kind   <= pend_kind;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ghct_checker.sv
module ghct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_term,
  input logic [1:0]  out_kind,
  input logic        out_last
);
  import ghct_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_term) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result changed");

  // only defined kinds
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_TERM || out_kind == KIND_END || out_kind == KIND_ERR))
    else $error("undefined result kind");

  // end and error carry no term and close the transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_TERM |-> out_term == 64'd0 && out_last)
    else $error("end or error malformed");

  // a non-final result means the input term is still being worked on
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken before run finished");

endmodule

bind generalized_cf_homographic_transform ghct_checker u_ghct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_term  (results.term),
  .out_kind  (results.kind),
  .out_last  (results.last_of_run)
);
